@@ hdl/itrd_pkg.sv @@
// Package for the integer-to-radix-digits converter: micro-op codes, the
// microcode word and its ROM, radix clamping and digit-to-ASCII helpers.
// No dependencies.
`default_nettype none

package itrd_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;  // 'A'

    // microcode addresses
    typedef enum logic [2:0] {
        UPC_IDLE  = 3'd0,
        UPC_MUL   = 3'd1,
        UPC_CMP   = 3'd2,
        UPC_SUB   = 3'd3,
        UPC_EMIT  = 3'd4,
        UPC_CHK   = 3'd5,
        UPC_LDPOW = 3'd6
    } t_upc;

    // datapath operation of one step; LOAD, CMP and SUB act only when the step's condition holds, the others always
    typedef enum logic [2:0] {
        UOP_LOAD  = 3'd0,  // take input, power = 1
        UOP_MUL   = 3'd1,  // save power, product = power * base
        UOP_CMP   = 3'd2,  // product fits: power = product, exponent++
        UOP_SUB   = 3'd3,  // value -= power, digit++
        UOP_EMIT  = 3'd4,  // present digit
        UOP_DEC   = 3'd5,  // exponent--, fetch lower power, clear digit
        UOP_LDPOW = 3'd6   // power = fetched power
    } t_uop;

    typedef enum logic [2:0] {
        COND_ALWAYS  = 3'd0,
        COND_IN_XFER = 3'd1,
        COND_PROD_LE = 3'd2,
        COND_VAL_GE  = 3'd3,
        COND_OUT_XFR = 3'd4,
        COND_LAST    = 3'd5
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_upc  jmp_true;
        t_upc  jmp_false;
    } t_uword;

    function automatic t_uword ucode_rom(input t_upc addr);
        t_uword w;
        case (addr)
            UPC_IDLE:  w = '{UOP_LOAD,  COND_IN_XFER, UPC_MUL,  UPC_IDLE};
            UPC_MUL:   w = '{UOP_MUL,   COND_ALWAYS,  UPC_CMP,  UPC_CMP};
            UPC_CMP:   w = '{UOP_CMP,   COND_PROD_LE, UPC_MUL,  UPC_SUB};
            UPC_SUB:   w = '{UOP_SUB,   COND_VAL_GE,  UPC_SUB,  UPC_EMIT};
            UPC_EMIT:  w = '{UOP_EMIT,  COND_OUT_XFR, UPC_CHK,  UPC_EMIT};
            UPC_CHK:   w = '{UOP_DEC,   COND_LAST,    UPC_IDLE, UPC_LDPOW};
            UPC_LDPOW: w = '{UOP_LDPOW, COND_ALWAYS,  UPC_SUB,  UPC_SUB};
            default:   w = '{UOP_LOAD,  COND_ALWAYS,  UPC_IDLE, UPC_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] c;
        if (r < RADIX_MIN) begin
            c = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            c = RADIX_MAX;
        end else begin
            c = r;
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DEC_DIGITS) begin
            ch = CHAR_ZERO + {1'b0, d};
        end else begin
            ch = CHAR_A + {1'b0, d - DEC_DIGITS};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ hdl/itrd_if.sv @@
// Valid/ready channel interfaces for the converter: input value channel
// and output digit channel. Depends on itrd_pkg.
`default_nettype none

interface itrd_in_if #(
    parameter int VALUE_WIDTH = 31
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itrd_out_if;
    logic                          valid;
    logic                          ready;
    logic [itrd_pkg::CHAR_W-1:0]   digit_char;
    logic                          is_last;

    modport source (output valid, output digit_char, output is_last, input ready);
    modport sink   (input valid, input digit_char, input is_last, output ready);
endinterface

`default_nettype wire

@@ hdl/integer_to_radix_digits.sv @@
// Sequence per value: a power search (multiply, compare) up to the power of the leading
// digit, then per digit repeated subtracts, an emit step (held while the output stalls)
// and a power fetch (check, load power) before the next digit. One value at a time: a
// new value is taken only when the sequencer is back in idle.
// Reset (i_rst_n, synchronous, active low) returns the sequencer to idle and the
// radix register to 10.
// Top level: microcoded sequencer, ROM and datapath. Depends on itrd_pkg, itrd_if.
`default_nettype none

module integer_to_radix_digits #(
    parameter int VALUE_WIDTH = 31
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [itrd_pkg::RADIX_W-1:0] i_cfg_data,
    itrd_in_if.sink                           i_in,
    itrd_out_if.source                        o_out
);
    import itrd_pkg::*;

    localparam int EXP_W  = $clog2(VALUE_WIDTH);
    localparam int PROD_W = VALUE_WIDTH + RADIX_W;

    t_upc                     r_step, n_step;
    t_uword                   uw;
    logic                     cond_true;

    logic [RADIX_W-1:0]       r_radix;
    logic [RADIX_W-1:0]       r_base, n_base;
    logic [VALUE_WIDTH-1:0]   r_value, n_value;
    logic [VALUE_WIDTH-1:0]   r_power, n_power;
    logic [PROD_W-1:0]        r_prod, n_prod;
    logic [EXP_W-1:0]         r_exp, n_exp;
    logic [RADIX_W-1:0]       r_digit, n_digit;
    logic [VALUE_WIDTH-1:0]   r_rd;
    logic [VALUE_WIDTH-1:0]   r_pow_mem [VALUE_WIDTH];

    logic                     prod_le;
    logic                     val_ge;
    logic                     is_last;

    assign uw      = ucode_rom(r_step);
    assign prod_le = r_prod <= {{RADIX_W{1'b0}}, r_value};
    assign val_ge  = r_value >= r_power;
    assign is_last = r_exp == '0;

    always_comb begin
        case (uw.cond)
            COND_ALWAYS:  cond_true = 1'b1;
            COND_IN_XFER: cond_true = i_in.valid;
            COND_PROD_LE: cond_true = prod_le;
            COND_VAL_GE:  cond_true = val_ge;
            COND_OUT_XFR: cond_true = o_out.ready;
            COND_LAST:    cond_true = is_last;
            default:      cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        n_step = cond_true ? uw.jmp_true : uw.jmp_false;
    end

    // handshake outputs
    always_comb begin
        i_in.ready       = uw.op == UOP_LOAD;
        o_out.valid      = uw.op == UOP_EMIT;
        o_out.digit_char = digit_to_ascii(r_digit);
        o_out.is_last    = is_last;
    end

    // datapath
    always_comb begin
        n_base  = r_base;
        n_value = r_value;
        n_power = r_power;
        n_prod  = r_prod;
        n_exp   = r_exp;
        n_digit = r_digit;
        case (uw.op)
            UOP_LOAD: begin
                if (cond_true) begin
                    n_base  = clamp_radix(r_radix);
                    n_value = i_in.value;
                    n_power = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
                    n_exp   = '0;
                    n_digit = '0;
                end
            end
            UOP_MUL: begin
                n_prod = r_power * r_base;
            end
            UOP_CMP: begin
                if (cond_true) begin
                    n_power = r_prod[VALUE_WIDTH-1:0];
                    n_exp   = r_exp + 1'b1;
                end
            end
            UOP_SUB: begin
                if (cond_true) begin
                    n_value = r_value - r_power;
                    n_digit = r_digit + 1'b1;
                end
            end
            UOP_EMIT: begin
            end
            UOP_DEC: begin
                // wraps after the last digit; reloaded at the next input
                n_exp   = r_exp - 1'b1;
                n_digit = '0;
            end
            UOP_LDPOW: begin
                n_power = r_rd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= UPC_IDLE;
            r_radix <= RADIX_RESET;
        end else begin
            r_step <= n_step;
            if (i_cfg_we) begin
                r_radix <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_value <= n_value;
        r_power <= n_power;
        r_prod  <= n_prod;
        r_exp   <= n_exp;
        r_digit <= n_digit;
    end

    // powers of the base, indexed by exponent
    always_ff @(posedge i_clk) begin
        if (uw.op == UOP_MUL) begin
            r_pow_mem[r_exp] <= r_power;
        end
        if (uw.op == UOP_DEC && !is_last) begin
            r_rd <= r_pow_mem[r_exp - 1'b1];
        end
    end

`ifndef SYNTHESIS
    a_digit_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_digit < r_base)
        else $error("digit not below base");

    a_remainder_below_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_value < r_power)
        else $error("remainder not below power at emit");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input taken while a digit is pending");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.is_last |-> ##2 i_in.ready)
        else $error("not idle after last digit");

    a_no_last_on_zero_exp_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.is_last |-> ##3 r_step == UPC_SUB)
        else $error("lower power not fetched after digit");
`endif

endmodule

`default_nettype wire

@@ tb/sv/integer_to_radix_digits_tb.sv @@
// Testbench for integer_to_radix_digits: feeds values through the input channel, predicts
// the digit string of each value in the current radix and checks every output transfer.
// Depends on itrd_pkg, itrd_if.sv and the integer_to_radix_digits RTL.
module integer_to_radix_digits_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itrd_pkg::*;

    localparam int VALUE_W = 31;
    localparam longint unsigned VALUE_MASK = (64'd1 << VALUE_W) - 1;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 6;
    localparam int VALUES_PER_PHASE = 15;

    typedef struct packed {
        logic [CHAR_W-1:0] glyph;
        logic              is_last;
    } t_digit;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [RADIX_W-1:0] i_cfg_data = '0;

    itrd_in_if #(.VALUE_WIDTH(VALUE_W)) in_ch ();
    itrd_out_if out_ch ();

    integer_to_radix_digits #(.VALUE_WIDTH(VALUE_W)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #4 i_clk = ~i_clk;

    logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
    logic [VALUE_W-1:0] value_q[$];
    t_digit             digits_due[$];
    int                 send_gap = 0;
    int                 recv_gap = 0;
    int                 gap_odds = 4;   // 1-in-N chance of a burst of idling, 0 = none
    bit                 drain_hold = 1'b0;
    int                 n_errors = 0;
    int                 n_values = 0;
    int                 n_digits = 0;
    int                 n_settings = 0;

    function automatic longint unsigned base_in_use();
        if (radix_shadow < RADIX_MIN) return RADIX_MIN;
        if (radix_shadow > RADIX_MAX) return RADIX_MAX;
        return radix_shadow;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_glyph(longint unsigned d);
        if (d < DEC_DIGITS) return CHAR_ZERO + CHAR_W'(d);
        return CHAR_A + CHAR_W'(d - DEC_DIGITS);
    endfunction

    // Expected digits of one value, most significant first
    function automatic void predict_digits(logic [VALUE_W-1:0] value);
        longint unsigned rest;
        longint unsigned base;
        longint unsigned power;
        longint unsigned d;
        bit              last;
        rest = value;
        base = base_in_use();
        power = 1;
        while (power <= rest / base) power *= base;
        do begin
            d = rest / power;
            last = (power <= 1);
            digits_due.push_back(t_digit'{digit_glyph(d), last});
            rest %= power;
            power /= base;
        end while (!last);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        longint unsigned base;
        longint unsigned p;
        longint unsigned v;
        int              k;
        base = base_in_use();
        case ($urandom_range(0, 3))
            0: v = $urandom & VALUE_MASK;
            1: v = $urandom_range(0, 2 * base * base);
            2: begin
                // around a power of the base: digit rollover and length changes
                p = 1;
                k = $urandom_range(1, VALUE_W);
                repeat (k) if (p * base <= VALUE_MASK) p *= base;
                v = p - 1 + $urandom_range(0, 2);
                if (v > VALUE_MASK) v = VALUE_MASK;
            end
            default: v = ($urandom & VALUE_MASK) >> $urandom_range(0, VALUE_W - 1);
        endcase
        return VALUE_W'(v);
    endfunction

    function automatic void flag_error(string what);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, what);
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (value_q.size() != 0 || in_ch.valid || digits_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] r);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        radix_shadow = r;
        n_settings++;
    endtask

    // Value driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.value <= '0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_digits(in_ch.value);
                n_values++;
                if (gap_odds != 0 && $urandom_range(1, 30) == 1) drain_hold = 1'b1;
            end
            if (drain_hold && digits_due.size() == 0) drain_hold = 1'b0;
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (value_q.size() != 0 && !drain_hold) begin
                    in_ch.valid <= 1'b1;
                    in_ch.value <= value_q.pop_front();
                    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
                        send_gap = $urandom_range(1, 14);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Digit monitor and checker
    always @(posedge i_clk) begin : digit_monitor
        t_digit want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_digits++;
                if (digits_due.size() == 0) begin
                    flag_error($sformatf("unexpected digit '%c' (0x%0h) is_last=%0b",
                                         out_ch.digit_char, out_ch.digit_char, out_ch.is_last));
                end else begin
                    want = digits_due.pop_front();
                    if (out_ch.digit_char !== want.glyph) begin
                        flag_error($sformatf("digit_char: expected '%c' (0x%0h), got 0x%0h",
                                             want.glyph, want.glyph, out_ch.digit_char));
                    end
                    if (out_ch.is_last !== want.is_last) begin
                        flag_error($sformatf("is_last: expected %0b, got %0b (digit '%c')",
                                             want.is_last, out_ch.is_last, want.glyph));
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
                    recv_gap = $urandom_range(1, 14);
                end
            end
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset radix is decimal
        value_q = {31'd0, 31'd1, 31'd9, 31'd10, 31'd999999999, 31'd1000000000, VALUE_MAX};
        wait_idle();
        set_radix(6'd2);
        value_q = {31'd0, 31'd1, 31'd2, 31'h5555_5555, 31'h2AAA_AAAA, VALUE_MAX};
        wait_idle();
        set_radix(6'd36);
        value_q = {31'd35, 31'd36, 31'd1295, 31'd1296, VALUE_MAX};
        wait_idle();
        // below the range: clamps to binary
        set_radix(6'd0);
        value_q = {31'd5};
        wait_idle();
        set_radix(6'd1);
        value_q = {31'd6};
        wait_idle();
        // above the range: clamps to base 36
        set_radix(6'd63);
        value_q = {31'd46655};
        wait_idle();
        set_radix(6'd37);
        value_q = {31'd36};
        wait_idle();
        set_radix(6'd16);
        value_q = {31'h4000_0000, 31'd255};
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: gap_odds = 3;
                1: gap_odds = 0;
                2: gap_odds = 6;
                3: gap_odds = 2;
                default: gap_odds = 0;  // closing phases run at full rate
            endcase
            set_radix(RADIX_W'($urandom_range(0, 63)));
            repeat (VALUES_PER_PHASE) value_q.push_back(pick_value());
            wait_idle();
        end

        $display("Converted %0d values into %0d digits across %0d radix writes,",
                 n_values, n_digits, n_settings);
        $display("clamped and extreme bases included; %0d mismatches.", n_errors);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout: %0d digits still outstanding, %0d values unsent",
                 digits_due.size(), value_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
